// ===== hw/rtl/mss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants of the MIDI step sequencer
// Operation codes, command word, configuration set and message forming.
// ----------------------------------------------------------------------------
package mss_pkg;

	// operation carried in tuser of the input stream
	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_KEY_DOWN = 2'd1,
		OP_KEY_UP   = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CHANNEL = 2'd0,
		REG_BASE    = 2'd1,
		REG_LOOP    = 2'd2,
		REG_NONE    = 2'd3
	} cfg_reg_t;

	// back end sequencing states
	typedef enum logic [3:0] {
		S_IDLE,   // waiting for a command word
		S_KOFF,   // note-off of the previously held key
		S_KON,    // note-on of the new key
		S_KUP,    // note-off on key release
		S_RD,     // ring read issued
		S_EVAL,   // ring entry available
		S_TPEND,  // flush pending note-off before next tick match
		S_TON,    // note-on of a matching tick entry
		S_TFIN,   // last pending note-off, step advance
		S_KREC    // record the new note
	} back_state_t;

	localparam int KEY_W  = 5;
	localparam int CHAN_W = 4;
	localparam int BYTE_W = 7;
	localparam int LEN_W  = 7;

	localparam logic [7:0]        STAT_ON   = 8'h90;
	localparam logic [7:0]        STAT_OFF  = 8'h80;
	localparam logic [BYTE_W-1:0] VEL_ON    = 7'h7F;
	localparam logic [BYTE_W-1:0] VEL_OFF   = 7'h00;
	localparam logic [BYTE_W-1:0] NOTE_MAX  = 7'h7F;

	localparam logic [CHAN_W-1:0] RST_CHANNEL = 4'd0;
	localparam logic [BYTE_W-1:0] RST_BASE    = 7'd48;
	localparam logic [LEN_W-1:0]  RST_LOOP    = 7'd64;

	// decoded command word between front and back
	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
	} cmd_t;

	// configuration set seen by the back end
	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [BYTE_W-1:0] base;
		logic [LEN_W-1:0]  loop_len;
	} cfg_t;

	// one MIDI message plus end-of-run flag
	typedef struct packed {
		logic              last;
		logic [BYTE_W-1:0] velocity;
		logic [BYTE_W-1:0] note;
		logic [7:0]        status;
	} msg_t;

	// form a note-on or note-off message, note byte saturated at 127
	function automatic msg_t make_msg(input logic on, input logic [KEY_W-1:0] key,
	                                  input cfg_t cfg, input logic last);
		msg_t       m;
		logic [7:0] sum;
		sum        = 8'(key) + 8'(cfg.base);
		m.status   = (on ? STAT_ON : STAT_OFF) | 8'(cfg.channel);
		m.note     = sum[7] ? NOTE_MAX : sum[BYTE_W-1:0];
		m.velocity = on ? VEL_ON : VEL_OFF;
		m.last     = last;
		return m;
	endfunction

endpackage

// ===== hw/rtl/mss_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_front: input side of the MIDI step sequencer
// Takes input words, decodes the operation and queues them for the back end.
// ----------------------------------------------------------------------------
module mss_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [4:0] key_number, rest zero
	input  logic [1:0]    s_tuser,   // [1:0] opcode
	output logic          cmd_valid,
	output mss_pkg::cmd_t cmd,
	input  logic          cmd_ready
);

	localparam int QD = 2;

	mss_pkg::cmd_t       fifo_q [QD];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;
	logic                push;
	logic                pop;
	mss_pkg::cmd_t       in_cmd;

	// decode the incoming word
	always_comb begin
		in_cmd.op  = mss_pkg::op_t'(s_tuser);
		in_cmd.key = s_tdata[mss_pkg::KEY_W-1:0];
	end

	assign s_tready  = (cnt_q != 2'(QD));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/mss_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_back: execution side of the MIDI step sequencer
// Runs one command at a time over the note ring and drives the output word.
// ----------------------------------------------------------------------------
module mss_back #(
	parameter int TABLE_DEPTH = 32,
	parameter int STEP_LIMIT  = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mss_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  mss_pkg::cmd_t cmd,
	output logic          cmd_ready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [23:0]   m_tdata,   // [7:0] status, [14:8] note, [21:15] velocity
	output logic          m_tlast
);

	localparam int PTR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int STEP_W = $clog2(STEP_LIMIT);
	localparam int ENT_W  = STEP_W + mss_pkg::KEY_W;
	localparam logic [mss_pkg::LEN_W-1:0] LEN_MAX = mss_pkg::LEN_W'(STEP_LIMIT);

	// note ring
	logic [ENT_W-1:0]          mem [TABLE_DEPTH];
	logic [ENT_W-1:0]          rdata_q;
	logic [PTR_W-1:0]          head_q, tail_q, rd_ptr_q;
	logic [CNT_W-1:0]          count_q, idx_q;

	// control and sequencer state
	mss_pkg::back_state_t      state_q, state_d;
	mss_pkg::op_t              op_q;
	logic [mss_pkg::KEY_W-1:0] key_q;
	logic [STEP_W-1:0]         step_q;
	logic                      held_q;
	logic [mss_pkg::KEY_W-1:0] held_key_q;
	logic                      pend_q;
	logic [mss_pkg::KEY_W-1:0] pend_key_q;

	// output register
	logic                      out_valid_q;
	mss_pkg::msg_t             out_q;

	logic                      can_load, out_load, emit, emit_on, emit_last, mem_we;
	logic [mss_pkg::KEY_W-1:0] emit_key;
	logic                      full, last_idx, match, advance;
	logic [STEP_W-1:0]         r_step;
	logic [mss_pkg::KEY_W-1:0] r_key;
	logic [mss_pkg::LEN_W-1:0] len_eff, step_inc;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(TABLE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign r_step   = rdata_q[ENT_W-1:mss_pkg::KEY_W];
	assign r_key    = rdata_q[mss_pkg::KEY_W-1:0];
	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign last_idx = (idx_q == count_q - 1'b1);
	assign match    = (r_step == step_q);
	assign can_load = !out_valid_q || m_tready;

	// effective loop length and step increment
	always_comb begin
		if (cfg.loop_len == '0) begin
			len_eff = mss_pkg::LEN_W'(1);
		end else if (cfg.loop_len > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = cfg.loop_len;
		end
		step_inc = mss_pkg::LEN_W'(step_q) + 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mss_pkg::S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						mss_pkg::OP_TICK:
							state_d = (count_q == '0) ? mss_pkg::S_TFIN : mss_pkg::S_RD;
						mss_pkg::OP_KEY_DOWN:
							if (held_q && held_key_q == cmd.key) state_d = mss_pkg::S_IDLE;
							else if (held_q) state_d = mss_pkg::S_KOFF;
							else state_d = mss_pkg::S_KON;
						mss_pkg::OP_KEY_UP:
							state_d = held_q ? mss_pkg::S_KUP : mss_pkg::S_IDLE;
						mss_pkg::OP_CLEAR:
							state_d = (count_q == '0) ? mss_pkg::S_IDLE : mss_pkg::S_RD;
						default: state_d = mss_pkg::S_IDLE;
					endcase
				end
			end
			mss_pkg::S_KOFF:  if (can_load) state_d = mss_pkg::S_KON;
			mss_pkg::S_KON:   if (can_load) state_d = full ? mss_pkg::S_RD : mss_pkg::S_KREC;
			mss_pkg::S_KUP:   if (can_load) state_d = mss_pkg::S_IDLE;
			mss_pkg::S_RD:    state_d = mss_pkg::S_EVAL;
			mss_pkg::S_EVAL: begin
				case (op_q)
					mss_pkg::OP_TICK:
						if (match) state_d = mss_pkg::S_TPEND;
						else state_d = last_idx ? mss_pkg::S_TFIN : mss_pkg::S_RD;
					mss_pkg::OP_CLEAR:
						if (can_load) state_d = last_idx ? mss_pkg::S_IDLE : mss_pkg::S_RD;
					mss_pkg::OP_KEY_DOWN:
						if (can_load) state_d = mss_pkg::S_KREC;
					default: state_d = mss_pkg::S_IDLE;
				endcase
			end
			mss_pkg::S_TPEND: if (!pend_q || can_load) state_d = mss_pkg::S_TON;
			mss_pkg::S_TON:   if (can_load) state_d = last_idx ? mss_pkg::S_TFIN : mss_pkg::S_RD;
			mss_pkg::S_TFIN:  if (!pend_q || can_load) state_d = mss_pkg::S_IDLE;
			mss_pkg::S_KREC:  state_d = mss_pkg::S_IDLE;
			default: state_d = mss_pkg::S_IDLE;
		endcase
	end

	// state outputs: message to send, pop and ring write
	always_comb begin
		cmd_ready = 1'b0;
		emit      = 1'b0;
		emit_on   = 1'b0;
		emit_last = 1'b0;
		emit_key  = held_key_q;
		mem_we    = 1'b0;
		case (state_q)
			mss_pkg::S_IDLE: cmd_ready = 1'b1;
			mss_pkg::S_KOFF: emit = 1'b1;
			mss_pkg::S_KON: begin
				emit      = 1'b1;
				emit_on   = 1'b1;
				emit_key  = key_q;
				emit_last = !full;
			end
			mss_pkg::S_KUP: begin
				emit      = 1'b1;
				emit_last = 1'b1;
			end
			mss_pkg::S_EVAL: begin
				emit_key = r_key;
				if (op_q == mss_pkg::OP_CLEAR) begin
					emit      = 1'b1;
					emit_last = last_idx;
				end else if (op_q == mss_pkg::OP_KEY_DOWN) begin
					emit      = 1'b1;
					emit_last = 1'b1;
				end
			end
			mss_pkg::S_TPEND: begin
				emit     = pend_q;
				emit_key = pend_key_q;
			end
			mss_pkg::S_TON: begin
				emit     = 1'b1;
				emit_on  = 1'b1;
				emit_key = r_key;
			end
			mss_pkg::S_TFIN: begin
				emit      = pend_q;
				emit_key  = pend_key_q;
				emit_last = 1'b1;
			end
			mss_pkg::S_KREC: mem_we = 1'b1;
			default: ;
		endcase
	end

	assign out_load = emit && can_load;
	assign advance  = (state_d == mss_pkg::S_RD) &&
	                  (state_q == mss_pkg::S_EVAL || state_q == mss_pkg::S_TON);

	// ring storage with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= {step_q, key_q};
		end
		rdata_q <= mem[rd_ptr_q];
	end

	// command payload and message payload
	always_ff @(posedge clk) begin
		if (state_q == mss_pkg::S_IDLE && cmd_valid) begin
			op_q  <= cmd.op;
			key_q <= cmd.key;
		end
		if (state_q == mss_pkg::S_TON && can_load) begin
			pend_key_q <= r_key;
		end
		if (out_load) begin
			out_q <= mss_pkg::make_msg(emit_on, emit_key, cfg, emit_last);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mss_pkg::S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			step_q      <= '0;
			held_q      <= 1'b0;
			held_key_q  <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// scan pointer
			if (state_q == mss_pkg::S_IDLE) begin
				rd_ptr_q <= head_q;
				idx_q    <= '0;
			end else if (advance) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
				idx_q    <= idx_q + 1'b1;
			end
			// pending note-off of a tick
			if (state_q == mss_pkg::S_TON && can_load) begin
				pend_q <= 1'b1;
			end
			// end of tick: drop pending flag, step forward
			if (state_q == mss_pkg::S_TFIN && (!pend_q || can_load)) begin
				pend_q <= 1'b0;
				step_q <= (step_inc >= len_eff) ? '0 : step_inc[STEP_W-1:0];
			end
			// clear empties the ring
			if (state_q == mss_pkg::S_EVAL && op_q == mss_pkg::OP_CLEAR &&
			    can_load && last_idx) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
			// record note, evicting oldest when full
			if (state_q == mss_pkg::S_KREC) begin
				tail_q     <= ptr_inc(tail_q);
				held_q     <= 1'b1;
				held_key_q <= key_q;
				if (full) begin
					head_q <= ptr_inc(head_q);
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == mss_pkg::S_KUP && can_load) begin
				held_q <= 1'b0;
			end
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.velocity, out_q.note, out_q.status};
	assign m_tlast  = out_q.last;

	// ring fill never exceeds its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("note count above table depth");

	// no pending note-off survives the end of a tick
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mss_pkg::S_IDLE) |-> !pend_q)
		else $error("pending note-off left in idle");

	// recording a note makes its key the held key
	a_rec_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mss_pkg::S_KREC) |=> (held_q && held_key_q == $past(key_q)))
		else $error("held key not updated on record");

	// idle never loads a message
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mss_pkg::S_IDLE) |-> !out_load)
		else $error("message loaded while idle");

endmodule

// ===== hw/rtl/midi_step_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_step_sequencer: looping step sequencer with MIDI message output
// Records notes in a ring, replays them per step, handles key down/up/clear.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | tuser opcode, tdata key_number
//  m_*      | out | m_tvalid/m_tready  | tdata status/note/velocity, tlast
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// Ticks and clears read each recorded note through the registered read of
//   the note ring.
// Reset clears the ring fill, step, held key and registers; ring data is not
//   cleared, only filled entries are ever read.
// A stalled output holds the back end; the two-entry input queue keeps
//   taking words meanwhile until it is full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module midi_step_sequencer #(
	parameter int TABLE_DEPTH = 32,
	parameter int STEP_LIMIT  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [4:0] key_number, [7:5] zero
	input  logic [1:0]  s_tuser,    // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [7:0] status, [14:8] note, [21:15] velocity
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	mss_pkg::cfg_t cfg_q;
	logic          cmd_valid;
	logic          cmd_ready;
	mss_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel  <= mss_pkg::RST_CHANNEL;
			cfg_q.base     <= mss_pkg::RST_BASE;
			cfg_q.loop_len <= mss_pkg::RST_LOOP;
		end else if (cfg_valid) begin
			case (mss_pkg::cfg_reg_t'(cfg_index))
				mss_pkg::REG_CHANNEL: cfg_q.channel  <= cfg_data[mss_pkg::CHAN_W-1:0];
				mss_pkg::REG_BASE:    cfg_q.base     <= cfg_data;
				mss_pkg::REG_LOOP:    cfg_q.loop_len <= cfg_data;
				default: ;
			endcase
		end
	end

	mss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	mss_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.STEP_LIMIT  (STEP_LIMIT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
